>>> rtl/core/ddes_pkg.sv
// ----------------------------------------------------------------------------
// ddes_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package ddes_pkg;

    localparam int NODE_COUNT = 64;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int EDGE_DEPTH = NODE_COUNT * NODE_COUNT;
    localparam int EDGE_W     = 2 * NODE_W;
    localparam int NTOT_W     = NODE_W + 1;
    localparam int ETOT_W     = 12;
    localparam int ACT_W      = 3;
    localparam int ST_W       = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 56;

    localparam logic [ACT_W-1:0] ACT_ADD   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REM   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RNODE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LOUT  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_LIN   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd6;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_DUP   = 2'd1;
    localparam logic [ST_W-1:0] ST_SELF  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_CLEAR, OP_RD1, OP_RD2, OP_RD3, OP_RD4,
        OP_ADD, OP_DEL, OP_NCNT, OP_NCHK, OP_NPICK, OP_DEG, OP_DCAP,
        OP_EMIT, OP_LRD, OP_LEMIT, OP_INIT
    } op_t;

    typedef struct packed {
        op_t             op;
        logic            ph_in;
        logic [ST_W-1:0] st;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             self_loop;
        logic             is_add;
        logic             is_list;
        logic             pres;
        logic             cnt_zero;
        logic             list_empty;
        logic             list_last;
        logic             out_free;
        logic             init_last;
    } sts_t;

endpackage

>>> rtl/core/ddes_ram.sv
// ----------------------------------------------------------------------------
// ddes_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ddes_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/ddes_datapath.sv
// ----------------------------------------------------------------------------
// ddes_datapath
// list and slot memories, degree memories, counters and result register
// ----------------------------------------------------------------------------
module ddes_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ddes_pkg::cmd_t                     cmd,
    output ddes_pkg::sts_t                     sts,
    input  logic [ddes_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ddes_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    output logic [ddes_pkg::ST_W-1:0]          m_tuser
);
    import ddes_pkg::*;

    logic [ACT_W-1:0]  act_reg;
    logic [NODE_W-1:0] sin_reg, din_reg, s_reg, d_reg;
    logic [NODE_W-1:0] cs_reg, cd_reg, ps_reg, pi_reg, od_reg, isd_reg;
    logic [NODE_W-1:0] degs_reg, degd_reg, idx_reg;
    logic              pres_reg;
    logic [NTOT_W-1:0] node_reg, node_next, src_reg, src_next;
    logic [ETOT_W-1:0] edge_reg, edge_next;
    logic [NODE_W-1:0] max_reg, max_next;
    logic [NODE_COUNT-1:0] oc_vld_reg, ic_vld_reg;
    logic              oc_vq_reg, ic_vq_reg;
    logic [EDGE_W-1:0] clr_reg;

    logic              mv_reg;
    logic [ST_W-1:0]   mst_reg;
    logic [NODE_W-1:0] mnb_reg;
    logic              mlast_reg;
    logic [2*NTOT_W+ETOT_W+3*NODE_W-1:0] mcnt_reg;

    logic              ol_we, il_we, os_we, is_we, oc_we, ic_we;
    logic              ol_re, il_re, os_re, is_re, oc_re, ic_re;
    logic [EDGE_W-1:0] ol_wa, il_wa, os_wa, is_wa, ol_ra, il_ra, e_addr;
    logic [NODE_W-1:0] ol_wd, il_wd, os_wd, is_wd, oc_wd, ic_wd;
    logic [NODE_W-1:0] oc_wa, ic_wa, oc_ra, ic_ra;
    logic [NODE_W-1:0] ol_q, il_q, os_q, is_q, oc_q, ic_q;
    logic [NODE_W-1:0] oc_eff, ic_eff, ncnt, lcnt, lq;

    assign oc_eff = oc_vq_reg ? oc_q : '0;
    assign ic_eff = ic_vq_reg ? ic_q : '0;
    assign ncnt   = cmd.ph_in ? ic_eff : oc_eff;
    assign lcnt   = (act_reg == ACT_LOUT) ? degs_reg : degd_reg;
    assign lq     = (act_reg == ACT_LOUT) ? ol_q : il_q;
    assign e_addr = {s_reg, d_reg};

    always_comb begin
        ol_we = 1'b0; il_we = 1'b0; os_we = 1'b0; is_we = 1'b0;
        oc_we = 1'b0; ic_we = 1'b0;
        ol_re = 1'b0; il_re = 1'b0; os_re = 1'b0; is_re = 1'b0;
        oc_re = 1'b0; ic_re = 1'b0;
        ol_wa = {s_reg, cs_reg}; ol_wd = d_reg;
        il_wa = {d_reg, cd_reg}; il_wd = s_reg;
        os_wa = e_addr; os_wd = cs_reg;
        is_wa = e_addr; is_wd = cd_reg;
        oc_wa = s_reg; oc_wd = cs_reg + NODE_W'(1);
        ic_wa = d_reg; ic_wd = cd_reg + NODE_W'(1);
        ol_ra = {s_reg, ps_reg};
        il_ra = {d_reg, cd_reg - NODE_W'(1)};
        oc_ra = s_reg; ic_ra = d_reg;
        case (cmd.op)
            OP_INIT: begin
                os_we = 1'b1;
                os_wa = clr_reg; os_wd = '0;
            end
            OP_RD1: begin
                oc_re = 1'b1; ic_re = 1'b1; os_re = 1'b1; is_re = 1'b1;
            end
            OP_RD2: begin
                oc_re = 1'b1; ic_re = 1'b1;
                oc_ra = d_reg; ic_ra = s_reg;
            end
            OP_RD3: begin
                ol_re = 1'b1;
            end
            OP_RD4: begin
                ol_re = 1'b1; il_re = 1'b1;
                ol_ra = {s_reg, cs_reg - NODE_W'(1)};
            end
            OP_ADD: begin
                ol_we = 1'b1; il_we = 1'b1; os_we = 1'b1; is_we = 1'b1;
                oc_we = 1'b1; ic_we = 1'b1;
            end
            OP_DEL: begin
                ol_we = 1'b1; il_we = 1'b1; os_we = 1'b1; is_we = 1'b1;
                oc_we = 1'b1; ic_we = 1'b1;
                ol_wa = {s_reg, ps_reg}; ol_wd = ol_q;
                il_wa = {d_reg, pi_reg}; il_wd = il_q;
                os_wa = {s_reg, ol_q};   os_wd = ps_reg;
                is_wa = {il_q, d_reg};   is_wd = pi_reg;
                oc_wd = cs_reg - NODE_W'(1);
                ic_wd = cd_reg - NODE_W'(1);
            end
            OP_NCNT: begin
                oc_re = ~cmd.ph_in; ic_re = cmd.ph_in;
                oc_ra = sin_reg; ic_ra = sin_reg;
            end
            OP_NCHK: begin
                ol_re = 1'b1; il_re = 1'b1;
                ol_ra = {sin_reg, ncnt - NODE_W'(1)};
                il_ra = {sin_reg, ncnt - NODE_W'(1)};
            end
            OP_DEG: begin
                oc_re = 1'b1; ic_re = 1'b1;
                oc_ra = sin_reg; ic_ra = din_reg;
            end
            OP_LRD: begin
                ol_re = 1'b1; il_re = 1'b1;
                ol_ra = {sin_reg, idx_reg};
                il_ra = {din_reg, idx_reg};
            end
            default: begin
            end
        endcase
    end

    ddes_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_DEPTH)) u_out_list (
        .aclk(aclk), .we(ol_we), .waddr(ol_wa), .wdata(ol_wd),
        .re(ol_re), .raddr(ol_ra), .rdata(ol_q));
    ddes_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_DEPTH)) u_in_list (
        .aclk(aclk), .we(il_we), .waddr(il_wa), .wdata(il_wd),
        .re(il_re), .raddr(il_ra), .rdata(il_q));
    ddes_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_DEPTH)) u_out_slot (
        .aclk(aclk), .we(os_we), .waddr(os_wa), .wdata(os_wd),
        .re(os_re), .raddr(e_addr), .rdata(os_q));
    ddes_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_DEPTH)) u_in_slot (
        .aclk(aclk), .we(is_we), .waddr(is_wa), .wdata(is_wd),
        .re(is_re), .raddr(e_addr), .rdata(is_q));
    ddes_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_out_cnt (
        .aclk(aclk), .we(oc_we), .waddr(oc_wa), .wdata(oc_wd),
        .re(oc_re), .raddr(oc_ra), .rdata(oc_q));
    ddes_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_in_cnt (
        .aclk(aclk), .we(ic_we), .waddr(ic_wa), .wdata(ic_wd),
        .re(ic_re), .raddr(ic_ra), .rdata(ic_q));

    always_comb begin
        node_next = node_reg;
        src_next  = src_reg;
        edge_next = edge_reg;
        max_next  = max_reg;
        case (cmd.op)
            OP_ADD: begin
                node_next = node_reg
                    + NTOT_W'((cs_reg == '0) && (isd_reg == '0))
                    + NTOT_W'((od_reg == '0) && (cd_reg == '0));
                src_next  = src_reg + NTOT_W'(cs_reg == '0);
                edge_next = edge_reg + ETOT_W'(1);
                if ((cd_reg + NODE_W'(1)) > max_reg) begin
                    max_next = cd_reg + NODE_W'(1);
                end
            end
            OP_DEL: begin
                node_next = node_reg
                    - NTOT_W'((cs_reg == NODE_W'(1)) && (isd_reg == '0))
                    - NTOT_W'((od_reg == '0) && (cd_reg == NODE_W'(1)));
                src_next  = src_reg - NTOT_W'(cs_reg == NODE_W'(1));
                edge_next = edge_reg - ETOT_W'(1);
            end
            OP_CLEAR: begin
                node_next = '0;
                src_next  = '0;
                edge_next = '0;
                max_next  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg   <= '0;
            src_reg    <= '0;
            edge_reg   <= '0;
            max_reg    <= '0;
            oc_vld_reg <= '0;
            ic_vld_reg <= '0;
            oc_vq_reg  <= 1'b0;
            ic_vq_reg  <= 1'b0;
            mv_reg     <= 1'b0;
            clr_reg    <= '0;
        end else begin
            node_reg <= node_next;
            src_reg  <= src_next;
            edge_reg <= edge_next;
            max_reg  <= max_next;
            if (cmd.op == OP_INIT) begin
                clr_reg <= clr_reg + EDGE_W'(1);
            end
            if (cmd.op == OP_CLEAR) begin
                oc_vld_reg <= '0;
                ic_vld_reg <= '0;
            end else begin
                if (oc_we) begin
                    oc_vld_reg[oc_wa] <= 1'b1;
                end
                if (ic_we) begin
                    ic_vld_reg[ic_wa] <= 1'b1;
                end
            end
            if (oc_re) begin
                oc_vq_reg <= oc_vld_reg[oc_ra];
            end
            if (ic_re) begin
                ic_vq_reg <= ic_vld_reg[ic_ra];
            end
            if (cmd.op == OP_EMIT || cmd.op == OP_LEMIT) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EMIT || cmd.op == OP_LEMIT) begin
            mcnt_reg <= {degd_reg, degs_reg, src_reg, max_reg, edge_reg, node_reg};
        end
        case (cmd.op)
            OP_LOAD: begin
                act_reg <= s_tdata[ACT_W-1:0];
                sin_reg <= s_tdata[ACT_W +: NODE_W];
                din_reg <= s_tdata[ACT_W+NODE_W +: NODE_W];
                s_reg   <= s_tdata[ACT_W +: NODE_W];
                d_reg   <= s_tdata[ACT_W+NODE_W +: NODE_W];
            end
            OP_RD2: begin
                cs_reg <= oc_eff;
                cd_reg <= ic_eff;
                ps_reg <= os_q;
                pi_reg <= is_q;
            end
            OP_RD3: begin
                od_reg  <= oc_eff;
                isd_reg <= ic_eff;
            end
            OP_RD4: begin
                pres_reg <= (ps_reg < cs_reg) && (ol_q == d_reg);
            end
            OP_NPICK: begin
                if (cmd.ph_in) begin
                    s_reg <= il_q;
                    d_reg <= sin_reg;
                end else begin
                    s_reg <= sin_reg;
                    d_reg <= ol_q;
                end
            end
            OP_DCAP: begin
                degs_reg <= oc_eff;
                degd_reg <= ic_eff;
                idx_reg  <= '0;
            end
            OP_EMIT: begin
                mst_reg   <= cmd.st;
                mnb_reg   <= '0;
                mlast_reg <= 1'b1;
            end
            OP_LEMIT: begin
                mst_reg   <= ST_DONE;
                mnb_reg   <= lq;
                mlast_reg <= (idx_reg == lcnt - NODE_W'(1));
                idx_reg   <= idx_reg + NODE_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign sts.act        = act_reg;
    assign sts.self_loop  = (s_reg == d_reg);
    assign sts.is_add     = (act_reg == ACT_ADD);
    assign sts.is_list    = (act_reg == ACT_LOUT) || (act_reg == ACT_LIN);
    assign sts.pres       = pres_reg;
    assign sts.cnt_zero   = (ncnt == '0);
    assign sts.list_empty = (lcnt == '0);
    assign sts.list_last  = (idx_reg == lcnt - NODE_W'(1));
    assign sts.out_free   = !mv_reg || m_tready;
    assign sts.init_last  = (clr_reg == '1);

    assign m_tvalid = mv_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = mst_reg;
    assign m_tdata  = {6'd0, mcnt_reg, mnb_reg};

endmodule

>>> rtl/core/ddes_ctrl.sv
// ----------------------------------------------------------------------------
// ddes_ctrl
// sequencer for edge updates, node removal, listing and result beats
// ----------------------------------------------------------------------------
module ddes_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ddes_pkg::sts_t sts,
    output ddes_pkg::cmd_t cmd
);
    import ddes_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_DISP  = 17'h00002,
        S_RD1   = 17'h00004,
        S_RD2   = 17'h00008,
        S_RD3   = 17'h00010,
        S_RD4   = 17'h00020,
        S_RD5   = 17'h00040,
        S_NCNT  = 17'h00080,
        S_NCHK  = 17'h00100,
        S_NPICK = 17'h00200,
        S_DEG   = 17'h00400,
        S_DCAP  = 17'h00800,
        S_LCHK  = 17'h01000,
        S_EMIT  = 17'h02000,
        S_LRD   = 17'h04000,
        S_LEMIT = 17'h08000,
        S_INIT  = 17'h10000
    } state_t;

    state_t          state_reg, state_next;
    logic [ST_W-1:0] st_reg, st_next;
    logic            nmode_reg, nmode_next;
    logic            ph_reg, ph_next;

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        nmode_next = nmode_reg;
        ph_next    = ph_reg;
        s_tready   = 1'b0;
        cmd.op     = OP_NOP;
        cmd.ph_in  = ph_reg;
        cmd.st     = st_reg;
        case (state_reg)
            S_INIT: begin
                cmd.op = OP_INIT;
                if (sts.init_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    st_next    = ST_DONE;
                    nmode_next = 1'b0;
                    ph_next    = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                case (sts.act)
                    ACT_ADD, ACT_REM: begin
                        if (sts.self_loop) begin
                            st_next    = ST_SELF;
                            state_next = S_DEG;
                        end else begin
                            state_next = S_RD1;
                        end
                    end
                    ACT_RNODE: begin
                        nmode_next = 1'b1;
                        state_next = S_NCNT;
                    end
                    ACT_CLEAR: begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_DEG;
                    end
                    default: begin
                        state_next = S_DEG;
                    end
                endcase
            end
            S_RD1: begin
                cmd.op     = OP_RD1;
                state_next = S_RD2;
            end
            S_RD2: begin
                cmd.op     = OP_RD2;
                state_next = S_RD3;
            end
            S_RD3: begin
                cmd.op     = OP_RD3;
                state_next = S_RD4;
            end
            S_RD4: begin
                cmd.op     = OP_RD4;
                state_next = S_RD5;
            end
            S_RD5: begin
                if (sts.is_add == sts.pres) begin
                    st_next = ST_DUP;
                end else begin
                    cmd.op = sts.is_add ? OP_ADD : OP_DEL;
                end
                state_next = nmode_reg ? S_NCNT : S_DEG;
            end
            S_NCNT: begin
                cmd.op     = OP_NCNT;
                state_next = S_NCHK;
            end
            S_NCHK: begin
                cmd.op = OP_NCHK;
                if (!sts.cnt_zero) begin
                    state_next = S_NPICK;
                end else if (!ph_reg) begin
                    ph_next    = 1'b1;
                    state_next = S_NCNT;
                end else begin
                    state_next = S_DEG;
                end
            end
            S_NPICK: begin
                cmd.op     = OP_NPICK;
                state_next = S_RD1;
            end
            S_DEG: begin
                cmd.op     = OP_DEG;
                state_next = S_DCAP;
            end
            S_DCAP: begin
                cmd.op     = OP_DCAP;
                state_next = sts.is_list ? S_LCHK : S_EMIT;
            end
            S_LCHK: begin
                if (sts.list_empty) begin
                    st_next    = ST_EMPTY;
                    state_next = S_EMIT;
                end else begin
                    state_next = S_LRD;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_LRD: begin
                cmd.op     = OP_LRD;
                state_next = S_LEMIT;
            end
            S_LEMIT: begin
                if (sts.out_free) begin
                    cmd.op     = OP_LEMIT;
                    state_next = sts.list_last ? S_IDLE : S_LRD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            st_reg    <= ST_DONE;
            nmode_reg <= 1'b0;
            ph_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
            nmode_reg <= nmode_next;
            ph_reg    <= ph_next;
        end
    end

endmodule

>>> rtl/core/dynamic_digraph_edge_store_unit.sv
// ----------------------------------------------------------------------------
// dynamic_digraph_edge_store_unit
// directed graph edge store with per-node out and in adjacency lists
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one command beat: action, src_node, dst_node.
//   m_ channel returns result beats; tuser carries the status, tlast marks
//   the final beat of a command. one command is processed at a time.
//   sequencer states per command before the result beat is loaded:
//     add / remove edge: DISP, RD1 to RD5, DEG, DCAP
//     query, clear, self loop: DISP, DEG, DCAP
//     remove node: DISP, NCNT, NCHK, NPICK, RD1 to RD5 per edge, DEG, DCAP
//     list out / list in: DISP, DEG, DCAP, LCHK, then LRD, LEMIT per neighbor
//   an empty list goes from LCHK to EMIT. list walks are paced by the single
//   read port of each list memory, walked one entry per step by the sequencer.
//   the result register frees the input side: a new command is taken the
//   cycle after the last beat is loaded, even while it waits on m_tready.
//   a stalled receiver holds the current beat and pauses list walks.
//   after reset the out slot memory is swept to zero with s_tready low;
//   counters and degree valid bits clear at once. list memories are never
//   cleared; entries are checked against the degrees.
// ----------------------------------------------------------------------------
module dynamic_digraph_edge_store_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action[2:0], src_node[8:3], dst_node[14:9]
    input  logic [ddes_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // neighbor[5:0], node_total[12:6], edge_total[24:13], max_in_bound[30:25],
    // sources_total[37:31], src_out_degree[43:38], dst_in_degree[49:44]
    output logic [ddes_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    // status[1:0]
    output logic [ddes_pkg::ST_W-1:0]       m_tuser
);
    import ddes_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ddes_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    ddes_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .sts(sts), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_EMIT || cmd.op == OP_LEMIT) |-> sts.out_free)
        else $error("result loaded over an untaken beat");

    a_src_le_node: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[37:31] <= m_tdata[12:6]))
        else $error("sources exceed active nodes");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_LOAD) |-> (s_tvalid && s_tready))
        else $error("command loaded without a beat");

    a_edge_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24:13] <= 12'd4032))
        else $error("edge count out of range");
`endif

endmodule
